// ===== rtl/s2rd_pkg.sv =====
package s2rd_pkg;

  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int CFG_W       = 64;
  localparam int COUNT_W     = 7;
  localparam int NUM_ENTRIES = 16;
  localparam int TABLE_W     = NUM_ENTRIES * CHAR_W;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd126;

  localparam logic [1:0] REG_RADIX     = 2'd0;
  localparam logic [1:0] REG_TABLE_LOW = 2'd1;
  localparam logic [1:0] REG_TABLE_HI  = 2'd2;

  typedef logic [2:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [2:0] upc_t;

  localparam op_t OP_IDLE  = 3'd0;
  localparam op_t OP_NOP   = 3'd1;
  localparam op_t OP_ERR   = 3'd2;
  localparam op_t OP_DAB   = 3'd3;
  localparam op_t OP_SIGN  = 3'd4;
  localparam op_t OP_DIGIT = 3'd5;

  localparam cond_t C_NEVER    = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_NO_INPUT = 3'd2;
  localparam cond_t C_TBL_OK   = 3'd3;
  localparam cond_t C_CNT_MORE = 3'd4;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic blocked;
    logic cnt_last;
  } dp_stat_t;

  // Step 0 waits for a word, steps 1-2 let the table check settle and branch,
  // step 3 reports a bad table, step 4 shifts the magnitude into the digit
  // array, steps 5-6 emit the sign and the digits.
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    unique case (addr)
      3'd0: w = '{op: OP_IDLE,  cond: C_NO_INPUT, target: 3'd0};
      3'd1: w = '{op: OP_NOP,   cond: C_NEVER,    target: 3'd0};
      3'd2: w = '{op: OP_NOP,   cond: C_TBL_OK,   target: 3'd4};
      3'd3: w = '{op: OP_ERR,   cond: C_ALWAYS,   target: 3'd0};
      3'd4: w = '{op: OP_DAB,   cond: C_CNT_MORE, target: 3'd4};
      3'd5: w = '{op: OP_SIGN,  cond: C_NEVER,    target: 3'd0};
      3'd6: w = '{op: OP_DIGIT, cond: C_CNT_MORE, target: 3'd6};
      3'd7: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/s2rd_tchk.sv =====
module s2rd_tchk #(
  parameter int MAX_RADIX = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [s2rd_pkg::RADIX_W-1:0]  radix,
  input  logic [s2rd_pkg::TABLE_W-1:0]  digit_table,
  output logic                          table_ok
);

  logic ok_r;
  logic ok_nxt;

  always_comb begin
    logic                        bad;
    logic                        in_use;
    logic [s2rd_pkg::CHAR_W-1:0] c;
    bad = (radix < 5'd2) || (radix > s2rd_pkg::RADIX_W'(MAX_RADIX));
    for (int i = 0; i < s2rd_pkg::NUM_ENTRIES; i++) begin
      c      = digit_table[i*s2rd_pkg::CHAR_W +: s2rd_pkg::CHAR_W];
      in_use = s2rd_pkg::RADIX_W'(i) < radix;
      if (in_use && (c == s2rd_pkg::CH_PLUS || c == s2rd_pkg::CH_MINUS ||
                     c < s2rd_pkg::CH_LOW || c > s2rd_pkg::CH_HIGH)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < s2rd_pkg::NUM_ENTRIES; j++) begin
        if (in_use && (s2rd_pkg::RADIX_W'(j) < radix) &&
            (digit_table[j*s2rd_pkg::CHAR_W +: s2rd_pkg::CHAR_W] == c)) begin
          bad = 1'b1;
        end
      end
    end
    ok_nxt = !bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= ok_nxt;
    end
  end

  assign table_ok = ok_r;

endmodule

// ===== rtl/s2rd_dpath.sv =====
module s2rd_dpath #(
  parameter int VALUE_BITS = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  s2rd_pkg::op_t                 op,
  input  logic                          in_valid,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  logic [s2rd_pkg::RADIX_W-1:0]  radix,
  input  logic [s2rd_pkg::TABLE_W-1:0]  digit_table,
  output s2rd_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2rd_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last_char,
  output logic [s2rd_pkg::COUNT_W-1:0]  out_char_count,
  output logic                          out_table_invalid
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int DW = s2rd_pkg::DIGIT_W;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [DW-1:0]         dig_r [VALUE_BITS];
  logic [DW-1:0]         dig_nxt [VALUE_BITS];
  logic [DW-1:0]         dig_dab [VALUE_BITS];
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ndig_r, ndig_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [s2rd_pkg::CHAR_W-1:0]         out_char_r, out_char_nxt;
  logic                                out_last_r, out_last_nxt;
  logic [s2rd_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                                out_inv_r, out_inv_nxt;

  logic [VALUE_BITS-1:0] gen, prop;
  logic [VALUE_BITS:0]   dsum;
  logic [VALUE_BITS:0]   carry;
  logic                  slot;
  logic                  want;
  logic                  blocked;
  logic [s2rd_pkg::CHAR_W-1:0]  e_char;
  logic                         e_last;
  logic                         e_inv;
  logic [s2rd_pkg::COUNT_W-1:0] total;
  logic [DW+2:0]                tsel;

  // One doubling step of the digit array. A digit generates a carry when
  // twice its value reaches the radix and passes the incoming carry on when
  // twice its value is one below the radix, so one wide add resolves all
  // carries at once.
  always_comb begin
    logic [s2rd_pkg::RADIX_W-1:0] two;
    logic [s2rd_pkg::RADIX_W-1:0] t;
    for (int i = 0; i < VALUE_BITS; i++) begin
      two     = {dig_r[i], 1'b0};
      gen[i]  = two >= radix;
      prop[i] = (two + 5'd1) == radix;
    end
    dsum  = {1'b0, gen | prop} + {1'b0, gen} + (VALUE_BITS+1)'(mag_r[VALUE_BITS-1]);
    carry = dsum ^ {1'b0, prop};
    for (int i = 0; i < VALUE_BITS; i++) begin
      t = {dig_r[i], 1'b0} + s2rd_pkg::RADIX_W'(carry[i]);
      if (carry[i+1]) begin
        t = t - radix;
      end
      dig_dab[i] = t[DW-1:0];
    end
  end

  assign slot  = !out_valid_r || !out_stall;
  assign total = s2rd_pkg::COUNT_W'(ndig_r) + s2rd_pkg::COUNT_W'(neg_r);
  assign tsel  = {dig_r[VALUE_BITS-1], 3'b000};

  always_comb begin
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    ndig_nxt = ndig_r;
    want     = 1'b0;
    e_char   = '0;
    e_last   = 1'b0;
    e_inv    = 1'b0;
    unique case (op)
      s2rd_pkg::OP_IDLE: begin
        if (in_valid) begin
          neg_nxt  = in_value[VALUE_BITS-1];
          mag_nxt  = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          for (int i = 0; i < VALUE_BITS; i++) begin
            dig_nxt[i] = '0;
          end
          cnt_nxt  = CW'(VALUE_BITS);
          ndig_nxt = CW'(1);
        end
      end
      s2rd_pkg::OP_NOP: begin
      end
      s2rd_pkg::OP_ERR: begin
        want   = 1'b1;
        e_last = 1'b1;
        e_inv  = 1'b1;
      end
      s2rd_pkg::OP_DAB: begin
        dig_nxt = dig_dab;
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (carry[ndig_r]) begin
          ndig_nxt = ndig_r + 1'b1;
        end
      end
      s2rd_pkg::OP_SIGN: begin
        want    = neg_r;
        e_char  = s2rd_pkg::CH_MINUS;
        cnt_nxt = CW'(VALUE_BITS);
      end
      s2rd_pkg::OP_DIGIT: begin
        want    = cnt_r <= ndig_r;
        e_char  = digit_table[tsel +: s2rd_pkg::CHAR_W];
        e_last  = cnt_r == CW'(1);
        cnt_nxt = cnt_r - 1'b1;
        for (int i = VALUE_BITS - 1; i > 0; i--) begin
          dig_nxt[i] = dig_r[i-1];
        end
        dig_nxt[0] = '0;
      end
      default: begin
      end
    endcase
    blocked = want && !slot;
    if (blocked) begin
      dig_nxt = dig_r;
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    out_inv_nxt   = out_inv_r;
    if (want && slot) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = e_char;
      out_last_nxt  = e_last;
      out_count_nxt = (e_last && !e_inv) ? total : '0;
      out_inv_nxt   = e_inv;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ndig_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ndig_r      <= ndig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    dig_r       <= dig_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  assign stat.blocked  = blocked;
  assign stat.cnt_last = cnt_r == CW'(1);

  assign out_valid         = out_valid_r;
  assign out_char_code     = out_char_r;
  assign out_last_char     = out_last_r;
  assign out_char_count    = out_count_r;
  assign out_table_invalid = out_inv_r;

endmodule

// ===== rtl/signed_integer_to_radix_digits.sv =====
// A word is built by one doubling step per input bit and then emitted by one
// step per digit position; a new word is accepted only once the sequencer is
// back in its wait step, and a stalled output holds the emit steps.
// A rejected digit table puts its single word on the output, registered from the error step.
// Synchronous active-low reset sets radix to 2, clears both table registers
// and returns the sequencer to its wait step with no word pending.
module signed_integer_to_radix_digits #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [s2rd_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last_char,
  output logic [s2rd_pkg::COUNT_W-1:0]  out_char_count,
  output logic                          out_table_invalid,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [s2rd_pkg::CFG_W-1:0]    cfg_data
);

  logic [s2rd_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [s2rd_pkg::CFG_W-1:0]   tbl_lo_r, tbl_lo_nxt;
  logic [s2rd_pkg::CFG_W-1:0]   tbl_hi_r, tbl_hi_nxt;
  s2rd_pkg::upc_t               upc_r, upc_nxt;

  s2rd_pkg::uword_t   uw;
  s2rd_pkg::dp_stat_t stat;
  logic               table_ok;
  logic               cond_true;

  always_comb begin
    radix_nxt  = radix_r;
    tbl_lo_nxt = tbl_lo_r;
    tbl_hi_nxt = tbl_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        s2rd_pkg::REG_RADIX:     radix_nxt  = cfg_data[s2rd_pkg::RADIX_W-1:0];
        s2rd_pkg::REG_TABLE_LOW: tbl_lo_nxt = cfg_data;
        s2rd_pkg::REG_TABLE_HI:  tbl_hi_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign uw = s2rd_pkg::ucode(upc_r);

  always_comb begin
    unique case (uw.cond)
      s2rd_pkg::C_NEVER:    cond_true = 1'b0;
      s2rd_pkg::C_ALWAYS:   cond_true = 1'b1;
      s2rd_pkg::C_NO_INPUT: cond_true = !in_valid;
      s2rd_pkg::C_TBL_OK:   cond_true = table_ok;
      s2rd_pkg::C_CNT_MORE: cond_true = !stat.cnt_last;
      default:              cond_true = 1'b0;
    endcase
    if (stat.blocked) begin
      upc_nxt = upc_r;
    end else if (cond_true) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= 5'd2;
      tbl_lo_r <= '0;
      tbl_hi_r <= '0;
      upc_r    <= '0;
    end else begin
      radix_r  <= radix_nxt;
      tbl_lo_r <= tbl_lo_nxt;
      tbl_hi_r <= tbl_hi_nxt;
      upc_r    <= upc_nxt;
    end
  end

  assign in_stall = uw.op != s2rd_pkg::OP_IDLE;

  s2rd_tchk #(
    .MAX_RADIX (MAX_RADIX)
  ) u_tchk (
    .clk         (clk),
    .rst_n       (rst_n),
    .radix       (radix_r),
    .digit_table ({tbl_hi_r, tbl_lo_r}),
    .table_ok    (table_ok)
  );

  s2rd_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (uw.op),
    .in_valid          (in_valid),
    .in_value          (in_value),
    .radix             (radix_r),
    .digit_table       ({tbl_hi_r, tbl_lo_r}),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_code     (out_char_code),
    .out_last_char     (out_last_char),
    .out_char_count    (out_char_count),
    .out_table_invalid (out_table_invalid)
  );

endmodule
